// ----- rtl/lfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes, request kinds and controller/datapath interface structs for
// the LFU replacement table.
// -----------------------------------------------------------------------------
package lfu_pkg;

   localparam int SLOTS      = 16;
   localparam int KEY_BITS   = 8;
   localparam int COUNT_BITS = 16;
   localparam int STAMP_BITS = 32;
   localparam int CSR_BITS   = 5;
   localparam int CSR_RESET  = 16;

   localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NUM_BITS   = $clog2(SLOTS + 1);

   // rsp_tdata: hit, inserted, evicted, evicted_key, vote_count,
   //            entry_valid, entry_key, entry_count
   localparam int RSP_BITS   = 3 + KEY_BITS + COUNT_BITS + 1 + KEY_BITS + COUNT_BITS;
   localparam int RSP_TBITS  = ((RSP_BITS + 7) / 8) * 8;
   localparam int REQ_TBITS  = ((KEY_BITS + 7) / 8) * 8;

   localparam logic REQ_VOTE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic start;   // capture request, clear scan state
      logic rescan;  // restart slot walk for the next readout word
      logic step;    // examine one slot
      logic emit;    // load result word, commit table update
   } cmd_type;

   typedef struct packed {
      logic scan_last;    // slot walk is on its final slot
      logic out_free;     // result register can take a word
      logic last_result;  // word about to be emitted ends the request
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/lfu_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept a request, walk the slots, emit words until the last one.
// -----------------------------------------------------------------------------
module lfu_ctrl
   import lfu_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_result) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rescan = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/lfu_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lfu_datapath
// Slot table, limit register, per-slot walk for match/victim/readout order,
// and the result register.
// -----------------------------------------------------------------------------
module lfu_datapath
   import lfu_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tuser,
   input  wire [REQ_TBITS-1:0]  req_tdata,
   input  wire                  csr_valid,
   input  wire [CSR_BITS-1:0]   csr_data,
   input  wire                  rsp_tready,
   output logic                 rsp_tvalid,
   output logic [RSP_TBITS-1:0] rsp_tdata,
   output logic                 rsp_tlast,
   input  cmd_type              cmd,
   output status_type           status
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // table
   logic                  slot_valid_ff [SLOTS];
   logic [KEY_BITS-1:0]   slot_key_ff   [SLOTS];
   logic [COUNT_BITS-1:0] slot_count_ff [SLOTS];
   logic [STAMP_BITS-1:0] slot_stamp_ff [SLOTS];
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic [CSR_BITS-1:0]   limit_ff;

   // request and walk state
   logic                  kind_ff, kind_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [NUM_BITS-1:0]   used_ff, used_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   found_idx_ff, found_idx_in;
   logic [COUNT_BITS-1:0] found_count_ff, found_count_in;
   logic                  free_ff, free_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic                  vic_ff, vic_in;
   logic [IDX_BITS-1:0]   vic_idx_ff, vic_idx_in;
   logic [KEY_BITS-1:0]   vic_key_ff, vic_key_in;
   logic [COUNT_BITS-1:0] vic_count_ff, vic_count_in;
   logic [STAMP_BITS-1:0] vic_stamp_ff, vic_stamp_in;
   logic                  best_ff, best_in;
   logic [KEY_BITS-1:0]   best_key_ff, best_key_in;
   logic [COUNT_BITS-1:0] best_count_ff, best_count_in;
   logic                  prev_set_ff, prev_set_in;
   logic [KEY_BITS-1:0]   prev_key_ff, prev_key_in;
   logic [NUM_BITS-1:0]   emit_cnt_ff, emit_cnt_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TBITS-1:0]  rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // table write port
   logic                  wr_en;
   logic                  wr_new;
   logic [IDX_BITS-1:0]   wr_idx;
   logic [COUNT_BITS-1:0] wr_count;

   logic                  cur_valid;
   logic [KEY_BITS-1:0]   cur_key;
   logic [COUNT_BITS-1:0] cur_count;
   logic [STAMP_BITS-1:0] cur_stamp;
   logic [NUM_BITS-1:0]   limit_now;
   logic                  need_evict;
   logic                  last_word;
   logic [COUNT_BITS-1:0] inc_count;

   logic                  r_hit, r_ins, r_ev, r_entry_valid;
   logic [KEY_BITS-1:0]   r_ev_key, r_entry_key;
   logic [COUNT_BITS-1:0] r_vote_count, r_entry_count;

   assign cur_valid = slot_valid_ff[idx_ff];
   assign cur_key   = slot_key_ff[idx_ff];
   assign cur_count = slot_count_ff[idx_ff];
   assign cur_stamp = slot_stamp_ff[idx_ff];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (limit_ff == '0) begin
         limit_now = NUM_BITS'(1);
      end else if (int'(limit_ff) > SLOTS) begin
         limit_now = NUM_BITS'(SLOTS);
      end else begin
         limit_now = NUM_BITS'(limit_ff);
      end
   end

   assign need_evict = (used_ff >= limit_now) || !free_ff;
   assign inc_count  = (found_count_ff == COUNT_MAX) ? found_count_ff
                                                     : found_count_ff + 1'b1;
   assign last_word  = (kind_ff == REQ_VOTE) || !best_ff ||
                       ((emit_cnt_ff + 1'b1) == used_ff);

   assign status.scan_last   = (idx_ff == IDX_BITS'(SLOTS - 1));
   assign status.out_free    = !rsp_valid_ff || rsp_tready;
   assign status.last_result = last_word;

   // walk one slot per cycle
   always_comb begin
      kind_in        = kind_ff;
      key_in         = key_ff;
      idx_in         = idx_ff;
      used_in        = used_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_count_in = found_count_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      vic_in         = vic_ff;
      vic_idx_in     = vic_idx_ff;
      vic_key_in     = vic_key_ff;
      vic_count_in   = vic_count_ff;
      vic_stamp_in   = vic_stamp_ff;
      best_in        = best_ff;
      best_key_in    = best_key_ff;
      best_count_in  = best_count_ff;
      prev_set_in    = prev_set_ff;
      prev_key_in    = prev_key_ff;
      emit_cnt_in    = emit_cnt_ff;

      if (cmd.start) begin
         kind_in     = req_tuser;
         key_in      = req_tdata[KEY_BITS-1:0];
         prev_set_in = 1'b0;
         emit_cnt_in = '0;
      end
      if (cmd.start || cmd.rescan) begin
         idx_in   = '0;
         used_in  = '0;
         found_in = 1'b0;
         free_in  = 1'b0;
         vic_in   = 1'b0;
         best_in  = 1'b0;
      end
      if (cmd.step) begin
         idx_in = idx_ff + 1'b1;
         if (cur_valid) begin
            used_in = used_ff + 1'b1;
            if (cur_key == key_ff) begin
               found_in       = 1'b1;
               found_idx_in   = idx_ff;
               found_count_in = cur_count;
            end
            if (!vic_ff || cur_count < vic_count_ff ||
                (cur_count == vic_count_ff && cur_stamp < vic_stamp_ff)) begin
               vic_in       = 1'b1;
               vic_idx_in   = idx_ff;
               vic_key_in   = cur_key;
               vic_count_in = cur_count;
               vic_stamp_in = cur_stamp;
            end
            if ((!prev_set_ff || cur_key > prev_key_ff) &&
                (!best_ff || cur_key < best_key_ff)) begin
               best_in       = 1'b1;
               best_key_in   = cur_key;
               best_count_in = cur_count;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = idx_ff;
         end
      end
      if (cmd.emit && kind_ff == REQ_READ && best_ff) begin
         prev_set_in = 1'b1;
         prev_key_in = best_key_ff;
         emit_cnt_in = emit_cnt_ff + 1'b1;
      end
   end

   // result word and table commit
   always_comb begin
      r_hit         = 1'b0;
      r_ins         = 1'b0;
      r_ev          = 1'b0;
      r_ev_key      = '0;
      r_vote_count  = '0;
      r_entry_valid = 1'b0;
      r_entry_key   = '0;
      r_entry_count = '0;
      wr_en         = 1'b0;
      wr_new        = 1'b0;
      wr_idx        = free_idx_ff;
      wr_count      = COUNT_BITS'(1);
      stamp_in      = stamp_ff;

      if (kind_ff == REQ_VOTE) begin
         if (found_ff) begin
            r_hit        = 1'b1;
            r_vote_count = inc_count;
            wr_en        = cmd.emit;
            wr_idx       = found_idx_ff;
            wr_count     = inc_count;
         end else begin
            r_ins        = 1'b1;
            r_vote_count = COUNT_BITS'(1);
            wr_new       = 1'b1;
            if (need_evict && vic_ff) begin
               r_ev     = 1'b1;
               r_ev_key = vic_key_ff;
               wr_idx   = vic_idx_ff;
               wr_en    = cmd.emit;
            end else begin
               wr_en    = cmd.emit && free_ff;
            end
         end
         if (cmd.emit) begin
            stamp_in = stamp_ff + 1'b1;
         end
      end else if (best_ff) begin
         r_entry_valid = 1'b1;
         r_entry_key   = best_key_ff;
         r_entry_count = best_count_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = last_word;
         rsp_data_in  = RSP_TBITS'({r_entry_count, r_entry_key, r_entry_valid,
                                    r_vote_count, r_ev_key, r_ev, r_ins, r_hit});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= CSR_BITS'(CSR_RESET);
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            slot_valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // walk state and result payload; start sets up everything before use
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      idx_ff         <= idx_in;
      used_ff        <= used_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      found_count_ff <= found_count_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      vic_ff         <= vic_in;
      vic_idx_ff     <= vic_idx_in;
      vic_key_ff     <= vic_key_in;
      vic_count_ff   <= vic_count_in;
      vic_stamp_ff   <= vic_stamp_in;
      best_ff        <= best_in;
      best_key_ff    <= best_key_in;
      best_count_ff  <= best_count_in;
      prev_set_ff    <= prev_set_in;
      prev_key_ff    <= prev_key_in;
      emit_cnt_ff    <= emit_cnt_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_count_ff[wr_idx] <= wr_count;
         if (wr_new) begin
            slot_key_ff[wr_idx]   <= key_ff;
            slot_stamp_ff[wr_idx] <= stamp_ff;
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/lfu_replacement_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lfu_replacement_table
// Least-frequently-used key table with oldest-insertion tie break.
// -----------------------------------------------------------------------------
// Usage:
//   req_* takes one request word: req_tuser is the kind (0 vote, 1 readout),
//   req_tdata carries the key. A vote yields one rsp word; a readout yields one
//   word per valid entry in ascending key order (or one empty word when the
//   table is empty), rsp_tlast marking the final word of the request.
//   csr_* writes the active slot limit; the user must write it only while the
//   block is idle, which the block itself does not enforce; it is always ready.
//   Timing: every result word needs one walk over all 16 slots, one slot per
//   cycle, followed by an emit step that waits while the result register is
//   full; a readout repeats the walk for each of its words. A new request is
//   taken once the last word of the previous one sits in the result register.
//   Reset empties the table, clears the stamp and sets the limit to 16.
//   When the receiver stalls, hold the word in the result register; the
//   sequencer waits in its emit step until that register frees up.
// -----------------------------------------------------------------------------
module lfu_replacement_table
   import lfu_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   // request channel
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire [REQ_TBITS-1:0]  req_tdata,   // key
   input  wire                  req_tuser,   // req_type
   // limit register write
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [CSR_BITS-1:0]   csr_data,    // active_slots
   // result channel
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [RSP_TBITS-1:0] rsp_tdata,   // hit, inserted, evicted, evicted_key,
                                             // vote_count, entry_valid, entry_key,
                                             // entry_count, zero pad
   output logic                 rsp_tlast    // last
);

   cmd_type    cmd;
   status_type status;

   // configuration never stalls
   assign csr_ready = 1'b1;

   lfu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfu_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire

// ----- verif/lfu_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lfu_checker
// Watches the request, limit and result channels of the LFU table, keeps its
// own copy of the table and compares every result word with the prediction.
// -----------------------------------------------------------------------------
module lfu_checker
   import lfu_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_tready,
   input  wire [REQ_TBITS-1:0]  req_tdata,   // key
   input  wire                  req_tuser,   // req_type
   input  wire                  csr_valid,
   input  wire                  csr_ready,
   input  wire [CSR_BITS-1:0]   csr_data,    // active_slots
   input  wire                  rsp_tvalid,
   input  wire                  rsp_tready,
   input  wire [RSP_TBITS-1:0]  rsp_tdata,   // hit, inserted, evicted, evicted_key,
                                             // vote_count, entry_valid, entry_key,
                                             // entry_count, zero pad
   input  wire                  rsp_tlast,   // last
   output int                   fail_count,
   output int                   expected_left
);

   localparam int OFS_HIT    = 0;
   localparam int OFS_INS    = 1;
   localparam int OFS_EVICT  = 2;
   localparam int OFS_EVKEY  = 3;
   localparam int OFS_VCOUNT = OFS_EVKEY + KEY_BITS;
   localparam int OFS_EVALID = OFS_VCOUNT + COUNT_BITS;
   localparam int OFS_EKEY   = OFS_EVALID + 1;
   localparam int OFS_ECOUNT = OFS_EKEY + KEY_BITS;

   typedef struct packed {
      logic                  hit;
      logic                  inserted;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
      logic [COUNT_BITS-1:0] vote_count;
      logic                  entry_valid;
      logic [KEY_BITS-1:0]   entry_key;
      logic [COUNT_BITS-1:0] entry_count;
      logic                  last;
   } table_word_type;

   logic                  slot_used  [SLOTS];
   logic [KEY_BITS-1:0]   slot_key   [SLOTS];
   logic [COUNT_BITS-1:0] slot_hits  [SLOTS];
   logic [STAMP_BITS-1:0] slot_born  [SLOTS];
   logic [STAMP_BITS-1:0] vote_stamp;
   logic [CSR_BITS-1:0]   slot_limit;

   table_word_type expected_words[$];

   initial begin
      fail_count    = 0;
      expected_left = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Append one predicted word at the tail of the queue.
   function automatic void queue_word(input table_word_type w);
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_key[i]  = '0;
         slot_hits[i] = '0;
         slot_born[i] = '0;
      end
      vote_stamp = '0;
   endfunction

   // Count up a present key, or place a new one, evicting the least used
   // entry (oldest insertion on equal counts) when the limit is reached.
   function automatic void apply_vote(input logic [KEY_BITS-1:0] key);
      int             found;
      int             free_idx;
      int             victim;
      int             used;
      int             lim;
      table_word_type w;
      found    = -1;
      free_idx = -1;
      victim   = -1;
      used     = 0;
      w        = '0;
      w.last   = 1'b1;
      lim      = int'(slot_limit);
      if (lim < 1) lim = 1;
      if (lim > SLOTS) lim = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i]) begin
            used++;
            if (slot_key[i] == key) found = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (found >= 0) begin
         if (slot_hits[found] != '1) slot_hits[found]++;
         w.hit        = 1'b1;
         w.vote_count = slot_hits[found];
      end else begin
         if (used >= lim || free_idx < 0) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!slot_used[i]) continue;
               if (victim < 0 || slot_hits[i] < slot_hits[victim] ||
                   (slot_hits[i] == slot_hits[victim] &&
                    slot_born[i] < slot_born[victim]))
                  victim = i;
            end
            if (victim >= 0) begin
               w.evicted         = 1'b1;
               w.evicted_key     = slot_key[victim];
               slot_used[victim] = 1'b0;
               free_idx          = victim;
            end
         end
         if (free_idx >= 0) begin
            slot_used[free_idx] = 1'b1;
            slot_key[free_idx]  = key;
            slot_hits[free_idx] = COUNT_BITS'(1);
            slot_born[free_idx] = vote_stamp;
         end
         w.inserted   = 1'b1;
         w.vote_count = COUNT_BITS'(1);
      end
      vote_stamp++;
      queue_word(w);
   endfunction

   // List the valid entries by ascending key; an empty table gives one
   // empty word.
   function automatic void list_entries();
      logic [SLOTS-1:0] taken;
      int               total;
      int               best;
      table_word_type   w;
      taken = '0;
      total = 0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i]) total++;
      if (total == 0) begin
         w      = '0;
         w.last = 1'b1;
         queue_word(w);
      end
      for (int k = 0; k < total; k++) begin
         best = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i] || taken[i]) continue;
            if (best < 0 || slot_key[i] < slot_key[best]) best = i;
         end
         taken[best]   = 1'b1;
         w             = '0;
         w.entry_valid = 1'b1;
         w.entry_key   = slot_key[best];
         w.entry_count = slot_hits[best];
         w.last        = (k == total - 1);
         queue_word(w);
      end
   endfunction

   task automatic compare_word(input table_word_type want);
      check_field("hit", rsp_tdata[OFS_HIT], want.hit);
      check_field("inserted", rsp_tdata[OFS_INS], want.inserted);
      check_field("evicted", rsp_tdata[OFS_EVICT], want.evicted);
      check_field("evicted_key", rsp_tdata[OFS_EVKEY +: KEY_BITS], want.evicted_key);
      check_field("vote_count", rsp_tdata[OFS_VCOUNT +: COUNT_BITS], want.vote_count);
      check_field("entry_valid", rsp_tdata[OFS_EVALID], want.entry_valid);
      check_field("entry_key", rsp_tdata[OFS_EKEY +: KEY_BITS], want.entry_key);
      check_field("entry_count", rsp_tdata[OFS_ECOUNT +: COUNT_BITS], want.entry_count);
      check_field("pad bits", rsp_tdata >> RSP_BITS, 0);
      check_field("last", rsp_tlast, want.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         slot_limit = CSR_BITS'(CSR_RESET);
         expected_words.delete();
      end else begin
         // results first: a word seen here always belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("result word 0x%0h with nothing expected",
                                         rsp_tdata));
            end else begin
               compare_word(expected_words[0]);
               void'(expected_words.pop_front());
            end
         end
         if (csr_valid && csr_ready) slot_limit = csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_VOTE) apply_vote(req_tdata[KEY_BITS-1:0]);
            else list_entries();
         end
      end
      expected_left <= expected_words.size();
   end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Drives votes, readouts and limit writes into the LFU table with random
// gaps and back-pressure; the checker beside the block predicts and compares.
// -----------------------------------------------------------------------------
module tb_top;
   import lfu_pkg::*;

   localparam int LONG_HOLD    = 400;  // receiver hold-off for the fill-up test
   localparam int DRAIN_CYCLES = 60;   // longer than one vote takes from accept to result
   localparam int PHASE_WORDS  = 36;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_TBITS-1:0] req_tdata  = '0;   // key
   logic                 req_tuser  = 1'b0; // req_type
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_BITS-1:0]  csr_data   = '0;   // active_slots
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_TBITS-1:0] rsp_tdata;         // hit, inserted, evicted, evicted_key,
                                            // vote_count, entry_valid, entry_key,
                                            // entry_count, zero pad
   logic                 rsp_tlast;         // last

   int   fail_count;
   int   expected_left;

   // idling knobs, changed per phase by the stimulus
   int   req_gap_pct = 0;
   int   rsp_gap_pct = 0;
   int   rsp_gap     = 0;
   logic hold_go     = 1'b0;
   logic holding     = 1'b0;

   always #6 clock = ~clock;

   lfu_replacement_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   lfu_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: drop tready for random stretches; hold it low throughout
   // the long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else if (holding) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= rsp_gap - 1;
      end else if ($urandom_range(0, 99) < rsp_gap_pct) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= idle_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Long hold-off, counted here so the sender keeps offering words meanwhile
   // and the block fills up and stalls its input.
   initial begin
      wait (hold_go);
      @(posedge clock);
      holding <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      holding <= 1'b0;
   end

   // Offer one request word and hold it until accepted. Valid stays high
   // straight into the next word when no gap is drawn.
   task automatic offer_word(input logic kind, input logic [KEY_BITS-1:0] key);
      int gap;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TBITS'(key);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic vote_for(input logic [KEY_BITS-1:0] key);
      offer_word(REQ_VOTE, key);
   endtask

   // The key field is ignored on readout; fill it with noise anyway.
   task automatic read_table();
      offer_word(REQ_READ, KEY_BITS'($urandom_range(0, 255)));
   endtask

   // Drop valid and wait until every predicted word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Pick a key from a narrow window so hits and evictions are common,
   // with a share of fully random keys as noise.
   function automatic logic [KEY_BITS-1:0] pick_key(input int base, input int span);
      if ($urandom_range(0, 99) < 85)
         return KEY_BITS'(base + $urandom_range(0, span - 1));
      return KEY_BITS'($urandom_range(0, 255));
   endfunction

   initial begin : stimulus
      int limits[8];
      int base;
      int span;
      limits = '{16, 2, 7, 1, 11, 16, 4, 13};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty readout, key extremes, a hit, then a readout
      read_table();
      vote_for(8'h00);
      vote_for(8'hFF);
      vote_for(8'h00);
      vote_for(8'h55);
      vote_for(8'hAA);
      read_table();

      // limit 0 acts as 1: every new key evicts
      wait_drained();
      write_limit(5'd0);
      vote_for(8'h07);
      vote_for(8'h08);
      read_table();

      // limit above the table size acts as the full table; fill it, then
      // push one more key to evict the oldest among the least used
      wait_drained();
      write_limit(5'd31);
      for (int i = 0; i < 12; i++) vote_for(KEY_BITS'(8'h10 + i));
      vote_for(8'hC3);
      read_table();

      // lower the limit below the fill: one eviction, the rest stays
      wait_drained();
      write_limit(5'd3);
      vote_for(8'h3C);
      read_table();

      // random phases over a range of limits, extremes included
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         write_limit(CSR_BITS'(limits[p]));
         // every third phase runs without idling on either side
         req_gap_pct = (p % 3 == 1) ? 0 : 35;
         rsp_gap_pct = (p % 3 == 1) ? 0 : 20;
         base        = $urandom_range(0, 255);
         span        = limits[p] + $urandom_range(1, 6);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 0 && n == 4) hold_go = 1'b1;
            if ($urandom_range(0, 99) < 12) read_table();
            else vote_for(pick_key(base, span));
         end
      end

      wait_drained();
      // catch any stray word after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_left == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Hard limit on run time, far above the slowest legal run.
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_datapath.sv
rtl/lfu_replacement_table.sv
verif/lfu_checker.sv
verif/tb_top.sv
